FILE: rtl/core/text_cell_buffer_editor_macros.svh
// Assertion macros for the checker of the text cell buffer editor.
`ifndef TEXT_CELL_BUFFER_EDITOR_MACROS_SVH
`define TEXT_CELL_BUFFER_EDITOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCBE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcbe assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TCBE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcbe assertion failed");

`endif

FILE: rtl/core/tcbe_pkg.sv
// Types and constants shared by the text cell buffer editor.
package tcbe_pkg;

    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 64;
    localparam int COL_W       = 7;
    localparam int ROW_W       = 6;
    localparam int ADDR_W      = COL_W + ROW_W;
    localparam int CELL_W      = 16;
    localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CELL_W-1:0] SPACE_CHAR   = 16'h0020;
    localparam logic [CELL_W-1:0] CH_BACKSPACE = 16'h0008;
    localparam logic [CELL_W-1:0] CH_TAB       = 16'h0009;
    localparam logic [CELL_W-1:0] CH_NEWLINE   = 16'h000A;
    localparam logic [CELL_W-1:0] CH_RETURN    = 16'h000D;
    localparam logic [CELL_W-1:0] CH_ESCAPE    = 16'h001B;

    localparam logic [1:0] REQ_KEY  = 2'd0;
    localparam logic [1:0] REQ_CHAR = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    localparam logic [3:0] KEY_HOME   = 4'd0;
    localparam logic [3:0] KEY_END    = 4'd1;
    localparam logic [3:0] KEY_TOP    = 4'd2;
    localparam logic [3:0] KEY_BOTTOM = 4'd3;
    localparam logic [3:0] KEY_LEFT   = 4'd4;
    localparam logic [3:0] KEY_RIGHT  = 4'd5;
    localparam logic [3:0] KEY_UP     = 4'd6;
    localparam logic [3:0] KEY_DOWN   = 4'd7;
    localparam logic [3:0] KEY_DELETE = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 4'd1;

    // Reset grid is 80 x 25, kept as last column and last row.
    localparam logic [COL_W-1:0] LAST_COL_RESET = 7'd79;
    localparam logic [ROW_W-1:0] LAST_ROW_RESET = 6'd24;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHAR,
        ST_DEL_RD,
        ST_DEL_WT,
        ST_DONE
    } seq_state_t;

    typedef enum logic [3:0] {
        CUR_NONE,
        CUR_HOME,
        CUR_END,
        CUR_TOP,
        CUR_BOTTOM,
        CUR_LEFT,
        CUR_RIGHT,
        CUR_UP,
        CUR_DOWN,
        CUR_NEXT_ROW,
        CUR_RETURN,
        CUR_ADVANCE,
        CUR_ORIGIN
    } cur_op_t;

    typedef struct packed {
        logic [COL_W-1:0] last_col;
        logic [ROW_W-1:0] last_row;
    } grid_limits_t;

    typedef struct packed {
        cur_op_t          op;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } cur_ctl_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } cur_res_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [3:0]        key_code;
        logic [CELL_W-1:0] char_code;
        logic [7:0]        repeat_count;
        logic [COL_W-1:0]  read_column;
        logic [ROW_W-1:0]  read_row;
    } req_item_t;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic [CELL_W-1:0] cell_value;
    } rsp_item_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CELL_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_ctl_t;

endpackage

FILE: rtl/core/tcbe_req_if.sv
// Request channel: one editing or read request per word.
interface tcbe_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic [3:0]                    key_code;
    logic [tcbe_pkg::CELL_W-1:0]   char_code;
    logic [7:0]                    repeat_count;
    logic [tcbe_pkg::COL_W-1:0]    read_column;
    logic [tcbe_pkg::ROW_W-1:0]    read_row;

    modport source (
        output valid, req_type, key_code, char_code, repeat_count, read_column, read_row,
        input  ready
    );
    modport sink (
        input  valid, req_type, key_code, char_code, repeat_count, read_column, read_row,
        output ready
    );
endinterface

FILE: rtl/core/tcbe_rsp_if.sv
// Response channel: cursor position and read cell, one word per request.
interface tcbe_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [tcbe_pkg::COL_W-1:0]  cursor_column;
    logic [tcbe_pkg::ROW_W-1:0]  cursor_row;
    logic [tcbe_pkg::CELL_W-1:0] cell_value;

    modport source (
        output valid, cursor_column, cursor_row, cell_value,
        input  ready
    );
    modport sink (
        input  valid, cursor_column, cursor_row, cell_value,
        output ready
    );
endinterface

FILE: rtl/core/tcbe_cfg_if.sv
// Configuration write channel: register index and write data.
interface tcbe_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tcbe_pkg::CFG_IDX_W-1:0]  index;
    logic [tcbe_pkg::CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: rtl/core/tcbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcbe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/tcbe_cursor_unit.sv
// Shared cursor step unit: one clamped move of the cursor per use.
module tcbe_cursor_unit (
    input  tcbe_pkg::cur_ctl_t     ctl,
    input  tcbe_pkg::grid_limits_t lim,
    output tcbe_pkg::cur_res_t     res
);

    logic                       col_below_end;
    logic                       row_below_end;
    logic [tcbe_pkg::ROW_W-1:0] row_down;

    assign col_below_end = ctl.col < lim.last_col;
    assign row_below_end = ctl.row < lim.last_row;
    // The last row sticks: moving down from it leaves the row as it is.
    assign row_down      = row_below_end ? ctl.row + 6'd1 : ctl.row;

    always_comb
    begin
        res.col = ctl.col;
        res.row = ctl.row;
        case (ctl.op)
            tcbe_pkg::CUR_NONE:
            begin
            end
            tcbe_pkg::CUR_HOME:     res.col = '0;
            tcbe_pkg::CUR_END:      res.col = lim.last_col;
            tcbe_pkg::CUR_TOP:      res.row = '0;
            tcbe_pkg::CUR_BOTTOM:   res.row = lim.last_row;
            tcbe_pkg::CUR_LEFT:
            begin
                if (ctl.col != '0)
                begin
                    res.col = ctl.col - 7'd1;
                end
            end
            tcbe_pkg::CUR_RIGHT:
            begin
                if (col_below_end)
                begin
                    res.col = ctl.col + 7'd1;
                end
            end
            tcbe_pkg::CUR_UP:
            begin
                if (ctl.row != '0)
                begin
                    res.row = ctl.row - 6'd1;
                end
            end
            tcbe_pkg::CUR_DOWN:     res.row = row_down;
            tcbe_pkg::CUR_NEXT_ROW: res.row = row_down;
            tcbe_pkg::CUR_RETURN:
            begin
                res.col = '0;
                res.row = row_down;
            end
            tcbe_pkg::CUR_ADVANCE:
            begin
                if (col_below_end)
                begin
                    res.col = ctl.col + 7'd1;
                end
                else
                begin
                    res.col = '0;
                    res.row = row_down;
                end
            end
            tcbe_pkg::CUR_ORIGIN:
            begin
                res.col = '0;
                res.row = '0;
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: rtl/core/tcbe_seq.sv
// Request sequencer: runs each request through the cursor unit and the cell RAM.
module tcbe_seq #(
    parameter int TAB_STOP = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_hit,
    input  tcbe_pkg::grid_limits_t      lim,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  tcbe_pkg::req_item_t         in_item,
    input  logic                        out_free,
    output logic                        res_valid,
    output tcbe_pkg::rsp_item_t         res_item,
    output tcbe_pkg::ram_ctl_t          ram,
    input  logic [tcbe_pkg::CELL_W-1:0] ram_rd_data
);

    tcbe_pkg::seq_state_t state_reg, state_next;

    logic [tcbe_pkg::COL_W-1:0]  col_reg, col_next;
    logic [tcbe_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [1:0]                  req_type_reg, req_type_next;
    logic [tcbe_pkg::CELL_W-1:0] ch_reg, ch_next;
    logic [7:0]                  cnt_reg, cnt_next;
    logic [tcbe_pkg::COL_W-1:0]  del_x_reg, del_x_next;
    logic                        del_char_reg, del_char_next;
    logic [tcbe_pkg::ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic                        clr_item_reg, clr_item_next;

    tcbe_pkg::cur_ctl_t cu_ctl;
    tcbe_pkg::cur_res_t cu_res;

    logic [tcbe_pkg::MAX_COLUMNS-1:0] tab_stop_vec;
    logic                             clr_last;
    logic                             cnt_last;
    logic                             del_more;
    logic                             tab_hit;

    // Columns that are tab stops, fixed at elaboration.
    for (genvar g = 0; g < tcbe_pkg::MAX_COLUMNS; g++)
    begin : g_tab
        assign tab_stop_vec[g] = ((g % TAB_STOP) == 0);
    end

    tcbe_cursor_unit u_cursor (
        .ctl (cu_ctl),
        .lim (lim),
        .res (cu_res)
    );

    assign clr_last = clr_addr_reg == '1;
    assign cnt_last = cnt_reg == 8'd1;
    assign del_more = del_x_reg < lim.last_col;
    assign tab_hit  = tab_stop_vec[cu_res.col];
    assign in_ready = state_reg == tcbe_pkg::ST_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tcbe_pkg::ST_CLEAR;
            col_reg      <= '0;
            row_reg      <= '0;
            clr_addr_reg <= '0;
            clr_item_reg <= 1'b0;
            del_char_reg <= 1'b0;
            cnt_reg      <= '0;
            req_type_reg <= tcbe_pkg::REQ_KEY;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            clr_addr_reg <= clr_addr_next;
            clr_item_reg <= clr_item_next;
            del_char_reg <= del_char_next;
            cnt_reg      <= cnt_next;
            req_type_reg <= req_type_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg    <= ch_next;
        del_x_reg <= del_x_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcbe_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = clr_item_reg ? tcbe_pkg::ST_DONE : tcbe_pkg::ST_IDLE;
                end
            end
            tcbe_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_item.req_type)
                        tcbe_pkg::REQ_KEY:
                        begin
                            state_next = (in_item.key_code == tcbe_pkg::KEY_DELETE)
                                       ? tcbe_pkg::ST_DEL_RD : tcbe_pkg::ST_DONE;
                        end
                        tcbe_pkg::REQ_CHAR:
                        begin
                            state_next = (in_item.repeat_count == '0)
                                       ? tcbe_pkg::ST_DONE : tcbe_pkg::ST_CHAR;
                        end
                        default: state_next = tcbe_pkg::ST_DONE;
                    endcase
                end
            end
            tcbe_pkg::ST_CHAR:
            begin
                case (ch_reg)
                    tcbe_pkg::CH_BACKSPACE:
                    begin
                        if (col_reg != '0)
                        begin
                            state_next = tcbe_pkg::ST_DEL_RD;
                        end
                        else if (cnt_last)
                        begin
                            state_next = tcbe_pkg::ST_DONE;
                        end
                    end
                    tcbe_pkg::CH_ESCAPE: state_next = tcbe_pkg::ST_CLEAR;
                    tcbe_pkg::CH_TAB:
                    begin
                        if (tab_hit && cnt_last)
                        begin
                            state_next = tcbe_pkg::ST_DONE;
                        end
                    end
                    default:
                    begin
                        if (cnt_last)
                        begin
                            state_next = tcbe_pkg::ST_DONE;
                        end
                    end
                endcase
            end
            tcbe_pkg::ST_DEL_RD:
            begin
                if (del_more)
                begin
                    state_next = tcbe_pkg::ST_DEL_WT;
                end
                else if (del_char_reg && !cnt_last)
                begin
                    state_next = tcbe_pkg::ST_CHAR;
                end
                else
                begin
                    state_next = tcbe_pkg::ST_DONE;
                end
            end
            tcbe_pkg::ST_DEL_WT: state_next = tcbe_pkg::ST_DEL_RD;
            tcbe_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = tcbe_pkg::ST_IDLE;
                end
            end
            default: state_next = tcbe_pkg::ST_IDLE;
        endcase
        // A column or row register write resizes the grid and starts a clearing pass.
        if (cfg_hit)
        begin
            state_next = tcbe_pkg::ST_CLEAR;
        end
    end

    // Outputs and datapath.
    always_comb
    begin
        cu_ctl.op      = tcbe_pkg::CUR_NONE;
        cu_ctl.col     = col_reg;
        cu_ctl.row     = row_reg;
        ram.wr_en      = 1'b0;
        ram.wr_addr    = {row_reg, col_reg};
        ram.wr_data    = tcbe_pkg::SPACE_CHAR;
        ram.rd_en      = 1'b0;
        ram.rd_addr    = {row_reg, del_x_reg + 7'd1};
        res_valid      = 1'b0;
        res_item.cursor_column = col_reg;
        res_item.cursor_row    = row_reg;
        res_item.cell_value    = (req_type_reg == tcbe_pkg::REQ_READ) ? ram_rd_data : '0;
        req_type_next  = req_type_reg;
        ch_next        = ch_reg;
        cnt_next       = cnt_reg;
        del_x_next     = del_x_reg;
        del_char_next  = del_char_reg;
        clr_addr_next  = clr_addr_reg;
        clr_item_next  = clr_item_reg;

        case (state_reg)
            tcbe_pkg::ST_CLEAR:
            begin
                ram.wr_en     = 1'b1;
                ram.wr_addr   = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 13'd1;
                if (clr_last && clr_item_reg)
                begin
                    cu_ctl.op = tcbe_pkg::CUR_ORIGIN;
                end
            end
            tcbe_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_type_next = in_item.req_type;
                    ch_next       = in_item.char_code;
                    cnt_next      = in_item.repeat_count;
                    del_x_next    = col_reg;
                    del_char_next = 1'b0;
                    clr_item_next = 1'b0;
                    case (in_item.req_type)
                        tcbe_pkg::REQ_KEY:
                        begin
                            case (in_item.key_code)
                                tcbe_pkg::KEY_HOME:   cu_ctl.op = tcbe_pkg::CUR_HOME;
                                tcbe_pkg::KEY_END:    cu_ctl.op = tcbe_pkg::CUR_END;
                                tcbe_pkg::KEY_TOP:    cu_ctl.op = tcbe_pkg::CUR_TOP;
                                tcbe_pkg::KEY_BOTTOM: cu_ctl.op = tcbe_pkg::CUR_BOTTOM;
                                tcbe_pkg::KEY_LEFT:   cu_ctl.op = tcbe_pkg::CUR_LEFT;
                                tcbe_pkg::KEY_RIGHT:  cu_ctl.op = tcbe_pkg::CUR_RIGHT;
                                tcbe_pkg::KEY_UP:     cu_ctl.op = tcbe_pkg::CUR_UP;
                                tcbe_pkg::KEY_DOWN:   cu_ctl.op = tcbe_pkg::CUR_DOWN;
                                default:              cu_ctl.op = tcbe_pkg::CUR_NONE;
                            endcase
                        end
                        tcbe_pkg::REQ_READ:
                        begin
                            ram.rd_en   = 1'b1;
                            ram.rd_addr = {in_item.read_row, in_item.read_column};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            tcbe_pkg::ST_CHAR:
            begin
                case (ch_reg)
                    tcbe_pkg::CH_BACKSPACE:
                    begin
                        if (col_reg != '0)
                        begin
                            cu_ctl.op     = tcbe_pkg::CUR_LEFT;
                            del_x_next    = cu_res.col;
                            del_char_next = 1'b1;
                        end
                        else
                        begin
                            cnt_next = cnt_reg - 8'd1;
                        end
                    end
                    tcbe_pkg::CH_TAB:
                    begin
                        ram.wr_en = 1'b1;
                        cu_ctl.op = tcbe_pkg::CUR_ADVANCE;
                        if (tab_hit)
                        begin
                            cnt_next = cnt_reg - 8'd1;
                        end
                    end
                    tcbe_pkg::CH_NEWLINE:
                    begin
                        cu_ctl.op = tcbe_pkg::CUR_NEXT_ROW;
                        cnt_next  = cnt_reg - 8'd1;
                    end
                    tcbe_pkg::CH_RETURN:
                    begin
                        cu_ctl.op = tcbe_pkg::CUR_RETURN;
                        cnt_next  = cnt_reg - 8'd1;
                    end
                    tcbe_pkg::CH_ESCAPE:
                    begin
                        // Further escapes in the same request change nothing more.
                        clr_addr_next = '0;
                        clr_item_next = 1'b1;
                    end
                    default:
                    begin
                        ram.wr_en   = 1'b1;
                        ram.wr_data = ch_reg;
                        cu_ctl.op   = tcbe_pkg::CUR_ADVANCE;
                        cnt_next    = cnt_reg - 8'd1;
                    end
                endcase
            end
            tcbe_pkg::ST_DEL_RD:
            begin
                if (del_more)
                begin
                    ram.rd_en = 1'b1;
                end
                else
                begin
                    ram.wr_en   = 1'b1;
                    ram.wr_addr = {row_reg, lim.last_col};
                    if (del_char_reg)
                    begin
                        cnt_next = cnt_reg - 8'd1;
                    end
                end
            end
            tcbe_pkg::ST_DEL_WT:
            begin
                ram.wr_en   = 1'b1;
                ram.wr_addr = {row_reg, del_x_reg};
                ram.wr_data = ram_rd_data;
                del_x_next  = del_x_reg + 7'd1;
            end
            tcbe_pkg::ST_DONE:
            begin
                res_valid = out_free;
            end
            default:
            begin
            end
        endcase

        col_next = cu_res.col;
        row_next = cu_res.row;
        if (cfg_hit)
        begin
            col_next      = '0;
            row_next      = '0;
            clr_addr_next = '0;
            clr_item_next = 1'b0;
        end
    end

endmodule

FILE: rtl/core/text_cell_buffer_editor.sv
// Text cell buffer editor: one request at a time through a shared cursor unit and cell RAM.
// Key moves, reads and unknown requests go straight to the response; characters run one
// printable, newline, return or tab-space step at a time; a delete shifts each cell right of
// the cursor left (registered RAM read, then write); a backspace moves left first.
// Escape, resizes and reset clear all 8192 cells, one a cycle, taking no request.
// Reset homes the cursor on an 80 x 25 grid; a stalled response word holds the block.
module text_cell_buffer_editor #(
    parameter int TAB_STOP = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    tcbe_req_if.sink   req,
    tcbe_rsp_if.source rsp,
    tcbe_cfg_if.sink   cfg
);

    tcbe_pkg::grid_limits_t      lim;
    logic [tcbe_pkg::COL_W-1:0]  last_col_reg, last_col_next;
    logic [tcbe_pkg::ROW_W-1:0]  last_row_reg, last_row_next;
    logic                        cfg_hit;
    logic                        cfg_write;

    tcbe_pkg::req_item_t         in_item;
    tcbe_pkg::rsp_item_t         res_item;
    tcbe_pkg::rsp_item_t         out_item_reg;
    logic                        out_valid_reg;
    logic                        out_free;
    logic                        res_valid;
    tcbe_pkg::ram_ctl_t          ram;
    logic [tcbe_pkg::CELL_W-1:0] ram_rd_data;
    logic [6:0]                  rows_value;

    assign cfg.ready  = 1'b1;
    assign cfg_write  = cfg.valid && cfg.ready;
    assign cfg_hit    = cfg_write
                     && (cfg.index == tcbe_pkg::CFG_COLUMNS || cfg.index == tcbe_pkg::CFG_ROWS);
    assign rows_value = cfg.data[6:0];

    // Register values are kept as the last usable column and row, clamped to the store.
    always_comb
    begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        if (cfg_write)
        begin
            case (cfg.index)
                tcbe_pkg::CFG_COLUMNS:
                begin
                    if (cfg.data == '0)
                    begin
                        last_col_next = '0;
                    end
                    else if (cfg.data > 8'(tcbe_pkg::MAX_COLUMNS))
                    begin
                        last_col_next = 7'(tcbe_pkg::MAX_COLUMNS - 1);
                    end
                    else
                    begin
                        last_col_next = 7'(cfg.data - 8'd1);
                    end
                end
                tcbe_pkg::CFG_ROWS:
                begin
                    if (rows_value == '0)
                    begin
                        last_row_next = '0;
                    end
                    else if (rows_value > 7'(tcbe_pkg::MAX_ROWS))
                    begin
                        last_row_next = 6'(tcbe_pkg::MAX_ROWS - 1);
                    end
                    else
                    begin
                        last_row_next = 6'(rows_value - 7'd1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= tcbe_pkg::LAST_COL_RESET;
            last_row_reg <= tcbe_pkg::LAST_ROW_RESET;
        end
        else
        begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
        end
    end

    assign lim.last_col = last_col_reg;
    assign lim.last_row = last_row_reg;

    assign in_item.req_type     = req.req_type;
    assign in_item.key_code     = req.key_code;
    assign in_item.char_code    = req.char_code;
    assign in_item.repeat_count = req.repeat_count;
    assign in_item.read_column  = req.read_column;
    assign in_item.read_row     = req.read_row;

    tcbe_seq #(
        .TAB_STOP (TAB_STOP)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_hit     (cfg_hit),
        .lim         (lim),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .in_item     (in_item),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res_item    (res_item),
        .ram         (ram),
        .ram_rd_data (ram_rd_data)
    );

    tcbe_ram #(
        .WIDTH (tcbe_pkg::CELL_W),
        .DEPTH (tcbe_pkg::CELL_COUNT)
    ) u_cells (
        .clk     (clk),
        .wr_en   (ram.wr_en),
        .wr_addr (ram.wr_addr),
        .wr_data (ram.wr_data),
        .rd_en   (ram.rd_en),
        .rd_addr (ram.rd_addr),
        .rd_data (ram_rd_data)
    );

    // Output register: a finished word waits here while the next request is taken.
    assign out_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_item_reg <= res_item;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.cursor_column = out_item_reg.cursor_column;
    assign rsp.cursor_row    = out_item_reg.cursor_row;
    assign rsp.cell_value    = out_item_reg.cell_value;

endmodule

FILE: rtl/core/tcbe_checker.sv
// Port-level checker for the text cell buffer editor and its bind to the top level.
`include "text_cell_buffer_editor_macros.svh"

module tcbe_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [tcbe_pkg::COL_W-1:0]      rsp_cursor_column,
    input logic [tcbe_pkg::ROW_W-1:0]      rsp_cursor_row,
    input logic [tcbe_pkg::CELL_W-1:0]     rsp_cell_value,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [tcbe_pkg::CFG_IDX_W-1:0]  cfg_index
);

    // The clearing pass after reset keeps requests out.
    `TCBE_ASSERT_NOW(a_reset_clears, $rose(rst_n), !req_ready)

    // One request at a time: the block is busy the cycle after it takes a word.
    `TCBE_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

    // A resize of the grid starts a clearing pass.
    `TCBE_ASSERT_NEXT(a_cfg_clears,
        cfg_valid && cfg_ready
        && (cfg_index == tcbe_pkg::CFG_COLUMNS || cfg_index == tcbe_pkg::CFG_ROWS),
        !req_ready)

    // A waiting response word holds until taken.
    `TCBE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_cursor_column) && $stable(rsp_cursor_row)
        && $stable(rsp_cell_value))

endmodule

bind text_cell_buffer_editor tcbe_checker u_tcbe_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_cursor_column (rsp.cursor_column),
    .rsp_cursor_row    (rsp.cursor_row),
    .rsp_cell_value    (rsp.cell_value),
    .cfg_valid         (cfg.valid),
    .cfg_ready         (cfg.ready),
    .cfg_index         (cfg.index)
);
